// ----- rtl/pcxrle_pkg.sv -----
// shared types, constants and the bit-to-pixel expansion for the pcx rle decoder
// no dependencies
`default_nettype none

package pcxrle_pkg;

  localparam int unsigned BplW    = 16;
  localparam int unsigned WidthW  = 17;
  localparam int unsigned HeightW = 17;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned RunW    = 6;
  localparam int unsigned PixW    = 64;

  localparam logic [BplW-1:0]    BplReset    = 16'd80;
  localparam logic [WidthW-1:0]  WidthReset  = 17'd640;
  localparam logic [HeightW-1:0] HeightReset = 17'd480;

  localparam logic [1:0] RunTag = 2'b11;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [1:0] REG_BPL    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] code;
    logic       is_run_hdr;
  } cmd_t;

  typedef struct packed {
    logic [BplW-1:0]    bytes_per_line;
    logic [WidthW-1:0]  image_width;
    logic [HeightW-1:0] image_height;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } back_state_e;

  function automatic logic [PixW-1:0] expand_byte(input logic [7:0] b);
    logic [PixW-1:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      r[j*8 +: 8] = {8{b[j]}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pcxrle_in_if.sv -----
// input channel of the pcx rle decoder: one code byte per beat
// depends on nothing
`default_nettype none

interface pcxrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/pcxrle_out_if.sv -----
// output channel of the pcx rle decoder: one decoded byte per beat
// depends on nothing
`default_nettype none

interface pcxrle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] pixels;
  logic [3:0]  valid_pixels;
  logic [15:0] line_number;
  logic [15:0] byte_in_line;
  logic        line_end;
  logic        last;
  logic        overflow;

  modport source (output valid, output pixels, output valid_pixels, output line_number,
                  output byte_in_line, output line_end, output last, output overflow,
                  input ready);
  modport sink (input valid, input pixels, input valid_pixels, input line_number,
                input byte_in_line, input line_end, input last, input overflow,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/pcx_rle_bitplane_decoder.sv -----
// top level of the pcx rle decoder for one-bit-per-pixel images
// depends on pcxrle_pkg, pcxrle_in_if, pcxrle_out_if, pcxrle_front, pcxrle_queue, pcxrle_back
`default_nettype none

// Decodes a PCX run-length coded 1bpp stream, one code byte per input beat, into one
// output beat per decoded byte (eight 0/255 pixels plus line position). The front
// takes a byte every cycle while the command queue (QueueDepth entries) has room.
// The back pulls at most one command per cycle while idle and emits one beat per
// cycle while the output is not stalled: a literal gives one beat, a run header
// none, a run value byte n beats for n copies (n <= 63, cut at line end), a byte
// after the last line one overflow beat. The back pops no new command while it is
// still emitting the beats of the last one. Config writes take effect on the next
// cycle and must only be made while the decoder is idle; index 3 is ignored.
module pcx_rle_bitplane_decoder #(
  parameter int unsigned QueueDepth = pcxrle_pkg::QueueDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  pcxrle_in_if.sink                         in_if,
  pcxrle_out_if.source                      out_if,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [pcxrle_pkg::CfgW-1:0]  cfg_wdata_i
);

  pcxrle_pkg::cfg_t cfg_q, cfg_d;
  pcxrle_pkg::cmd_t push_cmd, head;
  logic             push, full, pop, nonempty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pcxrle_pkg::REG_BPL:    cfg_d.bytes_per_line = cfg_wdata_i[pcxrle_pkg::BplW-1:0];
        pcxrle_pkg::REG_WIDTH:  cfg_d.image_width    = cfg_wdata_i;
        pcxrle_pkg::REG_HEIGHT: cfg_d.image_height   = cfg_wdata_i;
        default:                cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_line <= pcxrle_pkg::BplReset;
      cfg_q.image_width    <= pcxrle_pkg::WidthReset;
      cfg_q.image_height   <= pcxrle_pkg::HeightReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pcxrle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .push_cmd_o (push_cmd),
    .push_o     (push),
    .full_i     (full)
  );

  pcxrle_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (nonempty)
  );

  pcxrle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .nonempty_i (nonempty),
    .pop_o      (pop),
    .out_if     (out_if)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> nonempty)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue pushed while full");

  a_overflow_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.overflow) |->
      (out_if.last && !out_if.line_end && out_if.pixels == '0 && out_if.valid_pixels == '0))
    else $error("overflow beat carries data");

  a_line_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.line_end) |-> (out_if.last && out_if.valid_pixels <= 4'd8))
    else $error("line end beat not marked last");
`endif

endmodule

`default_nettype wire

// ----- rtl/pcxrle_front.sv -----
// front stage: accepts code bytes, tags run headers, pushes commands to the queue
// depends on pcxrle_pkg and pcxrle_in_if
`default_nettype none

module pcxrle_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  pcxrle_in_if.sink             in_if,
  output pcxrle_pkg::cmd_t      push_cmd_o,
  output logic                  push_o,
  input  wire logic             full_i
);

  logic             valid_q, valid_d;
  pcxrle_pkg::cmd_t cmd_q, cmd_d;
  logic             take;

  assign push_o      = valid_q && !full_i;
  assign in_if.ready = !valid_q || !full_i;
  assign take        = in_if.valid && in_if.ready;
  assign push_cmd_o  = cmd_q;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d          = 1'b1;
      cmd_d.code       = in_if.code_byte;
      cmd_d.is_run_hdr = (in_if.code_byte[7:6] == pcxrle_pkg::RunTag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

`default_nettype wire

// ----- rtl/pcxrle_queue.sv -----
// small command queue between the front and back stages
// depends on pcxrle_pkg
`default_nettype none

module pcxrle_queue #(
  parameter int unsigned Depth = pcxrle_pkg::QueueDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  pcxrle_pkg::cmd_t      push_cmd_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output pcxrle_pkg::cmd_t      head_o,
  output logic                  nonempty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pcxrle_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == FullCnt);
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pcxrle_back.sv -----
// back stage: run expansion, line tracking and the registered result beat
// depends on pcxrle_pkg and pcxrle_out_if
`default_nettype none

module pcxrle_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  pcxrle_pkg::cfg_t      cfg_i,
  input  pcxrle_pkg::cmd_t      head_i,
  input  wire logic             nonempty_i,
  output logic                  pop_o,
  pcxrle_out_if.source          out_if
);

  localparam int unsigned RunW = pcxrle_pkg::RunW;
  localparam int unsigned BplW = pcxrle_pkg::BplW;
  localparam int unsigned LcW  = pcxrle_pkg::HeightW;
  localparam int unsigned PosW = BplW + 3;

  pcxrle_pkg::back_state_e st_q, st_d;
  logic            exp_q, exp_d;
  logic [RunW-1:0] run_q, run_d;
  logic [RunW-1:0] left_q, left_d;
  logic [7:0]      byte_q, byte_d;
  logic [BplW-1:0] lbc_q, lbc_d;
  logic [LcW-1:0]  lc_q, lc_d;

  logic        ov_q, ov_d;
  logic        o_valid_q, o_valid_d;
  logic [63:0] o_pix_q, o_pix_d;
  logic [3:0]  o_vp_q, o_vp_d;
  logic [15:0] o_ln_q, o_ln_d;
  logic [15:0] o_bil_q, o_bil_d;
  logic        o_end_q, o_end_d;
  logic        o_last_q, o_last_d;

  logic            slot_free, done, ends, em_last;
  logic [PosW-1:0] pos, width_x, diff;
  logic [3:0]      vp;

  assign slot_free = !o_valid_q || out_if.ready;
  assign done      = (lc_q >= cfg_i.image_height);

  assign pos     = {lbc_q, 3'b000};
  assign width_x = PosW'(cfg_i.image_width);
  assign diff    = width_x - pos;
  assign vp      = (width_x <= pos) ? 4'd0 : ((diff >= PosW'(8)) ? 4'd8 : diff[3:0]);
  assign ends    = ({1'b0, lbc_q} + 17'd1) >= {1'b0, cfg_i.bytes_per_line};
  assign em_last = ends || (left_q == RunW'(1));

  always_comb begin
    st_d      = st_q;
    exp_d     = exp_q;
    run_d     = run_q;
    left_d    = left_q;
    byte_d    = byte_q;
    lbc_d     = lbc_q;
    lc_d      = lc_q;
    pop_o     = 1'b0;
    o_valid_d = o_valid_q && !out_if.ready;
    o_pix_d   = o_pix_q;
    o_vp_d    = o_vp_q;
    o_ln_d    = o_ln_q;
    o_bil_d   = o_bil_q;
    o_end_d   = o_end_q;
    o_last_d  = o_last_q;
    ov_d      = ov_q;
    case (st_q)
      pcxrle_pkg::ST_IDLE: begin
        if (nonempty_i) begin
          if (done) begin
            if (slot_free) begin
              pop_o     = 1'b1;
              o_valid_d = 1'b1;
              o_pix_d   = '0;
              o_vp_d    = '0;
              o_ln_d    = '0;
              o_bil_d   = '0;
              o_end_d   = 1'b0;
              o_last_d  = 1'b1;
              ov_d      = 1'b1;
            end
          end else begin
            pop_o  = 1'b1;
            byte_d = head_i.code;
            if (exp_q) begin
              exp_d  = 1'b0;
              run_d  = '0;
              left_d = run_q;
              if (run_q != '0) begin
                st_d = pcxrle_pkg::ST_EMIT;
              end
            end else if (head_i.is_run_hdr) begin
              exp_d = 1'b1;
              run_d = head_i.code[RunW-1:0];
            end else begin
              left_d = RunW'(1);
              st_d   = pcxrle_pkg::ST_EMIT;
            end
          end
        end
      end
      pcxrle_pkg::ST_EMIT: begin
        if (slot_free) begin
          o_valid_d = 1'b1;
          o_pix_d   = pcxrle_pkg::expand_byte(byte_q);
          o_vp_d    = vp;
          o_ln_d    = lc_q[15:0];
          o_bil_d   = lbc_q;
          o_end_d   = ends;
          o_last_d  = em_last;
          ov_d      = 1'b0;
          left_d    = left_q - RunW'(1);
          if (ends) begin
            lbc_d = '0;
            lc_d  = lc_q + LcW'(1);
          end else begin
            lbc_d = lbc_q + BplW'(1);
          end
          if (em_last) begin
            st_d = pcxrle_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        st_d = pcxrle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= pcxrle_pkg::ST_IDLE;
      exp_q     <= 1'b0;
      run_q     <= '0;
      lbc_q     <= '0;
      lc_q      <= '0;
      o_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      exp_q     <= exp_d;
      run_q     <= run_d;
      lbc_q     <= lbc_d;
      lc_q      <= lc_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q   <= left_d;
    byte_q   <= byte_d;
    o_pix_q  <= o_pix_d;
    o_vp_q   <= o_vp_d;
    o_ln_q   <= o_ln_d;
    o_bil_q  <= o_bil_d;
    o_end_q  <= o_end_d;
    o_last_q <= o_last_d;
    ov_q     <= ov_d;
  end

  assign out_if.valid        = o_valid_q;
  assign out_if.pixels       = o_pix_q;
  assign out_if.valid_pixels = o_vp_q;
  assign out_if.line_number  = o_ln_q;
  assign out_if.byte_in_line = o_bil_q;
  assign out_if.line_end     = o_end_q;
  assign out_if.last         = o_last_q;
  assign out_if.overflow     = ov_q;

endmodule

`default_nettype wire

// ----- test/pcx_rle_bitplane_decoder_tb.sv -----
// self-checking testbench for pcx_rle_bitplane_decoder: directed and random code bytes
// with gaps on both channels, decoded bytes predicted in-bench and checked beat by beat
// depends on pcxrle_pkg, pcxrle_in_if, pcxrle_out_if and the decoder rtl
`timescale 1ns / 100ps

module pcx_rle_bitplane_decoder_tb;

  localparam int StuckLimit = 4000;
  localparam int HoldCycles = 500;
  localparam int SettleCycles = 16;
  localparam int RandomItems = 287;

  typedef struct packed {
    logic [63:0] pixels;
    logic [3:0]  valid_pixels;
    logic [15:0] line_number;
    logic [15:0] byte_in_line;
    logic        line_end;
    logic        last;
    logic        overflow;
  } decoded_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [pcxrle_pkg::CfgW-1:0] cfg_wdata;

  pcxrle_in_if in_ch ();
  pcxrle_out_if out_ch ();

  pcx_rle_bitplane_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // register shadows and decoder state
  logic [pcxrle_pkg::BplW-1:0]    bpl_reg = pcxrle_pkg::BplReset;
  logic [pcxrle_pkg::WidthW-1:0]  width_reg = pcxrle_pkg::WidthReset;
  logic [pcxrle_pkg::HeightW-1:0] height_reg = pcxrle_pkg::HeightReset;
  logic                           run_armed = 1'b0;
  logic [pcxrle_pkg::RunW-1:0]    run_left = '0;
  logic [15:0]                    col_byte = '0;
  logic [16:0]                    line_idx = '0;

  logic [7:0]    pending_codes[$];
  decoded_byte_t due_bytes[$];

  int mismatches = 0;
  int stuck_cycles = 0;
  logic hold_armed;
  logic hold_done;

  int src_wait, src_calm, src_gap;
  int snk_wait, snk_calm, snk_gap;
  logic src_taken, snk_taken;
  decoded_byte_t seen;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] spread_bits(input logic [7:0] b);
    logic [63:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      r[63-8*j -: 8] = b[7-j] ? 8'hFF : 8'h00;
    end
    return r;
  endfunction

  task automatic decode_code_byte(input logic [7:0] b);
    int copies;
    int pos;
    decoded_byte_t d;
    d = '0;
    if (line_idx >= height_reg) begin
      d.last = 1'b1;
      d.overflow = 1'b1;
      due_bytes.push_back(d);
      return;
    end
    if (!run_armed) begin
      if (b[7:6] == pcxrle_pkg::RunTag) begin
        run_left = b[5:0];
        run_armed = 1'b1;
        return;
      end
      copies = 1;
    end else begin
      run_armed = 1'b0;
      copies = run_left;
      run_left = '0;
    end
    for (int k = 0; k < copies; k++) begin
      pos = int'(col_byte) * 8;
      d = '0;
      d.pixels = spread_bits(b);
      if (int'(width_reg) > pos) begin
        d.valid_pixels = (int'(width_reg) - pos > 8) ? 4'd8 : 4'(int'(width_reg) - pos);
      end
      d.line_number = line_idx[15:0];
      d.byte_in_line = col_byte;
      d.line_end = ({1'b0, col_byte} + 17'd1) >= {1'b0, bpl_reg};
      d.last = d.line_end || (k == copies - 1);
      due_bytes.push_back(d);
      if (d.line_end) begin
        col_byte = '0;
        line_idx = line_idx + 17'd1;
        break;
      end
      col_byte = col_byte + 16'd1;
    end
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    $display("%0t: %s expected %0h got %0h", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.code_byte <= '0;
      src_wait <= 0;
      src_calm <= 0;
    end else begin
      src_taken = in_ch.valid && in_ch.ready;
      if (src_taken) begin
        decode_code_byte(in_ch.code_byte);
        void'(pending_codes.pop_front());
      end
      if (!in_ch.valid || src_taken) begin
        if (src_wait > 0) begin
          in_ch.valid <= 1'b0;
          src_wait <= src_wait - 1;
        end else begin
          src_gap = 0;
          if (src_taken) begin
            if (src_calm > 0) begin
              src_calm <= src_calm - 1;
            end else begin
              src_gap = pick_gap();
              if ($urandom_range(0, 49) == 0) src_calm <= $urandom_range(30, 80);
            end
          end
          if (src_gap > 0 || pending_codes.size() == 0) begin
            in_ch.valid <= 1'b0;
            src_wait <= (src_gap > 0) ? src_gap - 1 : 0;
          end else begin
            in_ch.valid <= 1'b1;
            in_ch.code_byte <= pending_codes[0];
          end
        end
      end
    end
  end

  // sink side and beat checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      snk_wait <= 0;
      snk_calm <= 0;
      hold_done <= 1'b0;
    end else begin
      snk_taken = out_ch.valid && out_ch.ready;
      if (snk_taken) begin
        if (due_bytes.size() == 0) begin
          $display("%0t: unexpected beat, expected none got pixels %0h overflow %0b",
                   $time, out_ch.pixels, out_ch.overflow);
          mismatches++;
        end else begin
          seen = due_bytes.pop_front();
          if (out_ch.pixels !== seen.pixels)
            note_mismatch("pixels", seen.pixels, out_ch.pixels);
          if (out_ch.valid_pixels !== seen.valid_pixels)
            note_mismatch("valid_pixels", 64'(seen.valid_pixels), 64'(out_ch.valid_pixels));
          if (out_ch.line_number !== seen.line_number)
            note_mismatch("line_number", 64'(seen.line_number), 64'(out_ch.line_number));
          if (out_ch.byte_in_line !== seen.byte_in_line)
            note_mismatch("byte_in_line", 64'(seen.byte_in_line), 64'(out_ch.byte_in_line));
          if (out_ch.line_end !== seen.line_end)
            note_mismatch("line_end", 64'(seen.line_end), 64'(out_ch.line_end));
          if (out_ch.last !== seen.last)
            note_mismatch("last", 64'(seen.last), 64'(out_ch.last));
          if (out_ch.overflow !== seen.overflow)
            note_mismatch("overflow", 64'(seen.overflow), 64'(out_ch.overflow));
        end
      end
      if (hold_armed && !hold_done) begin
        hold_done <= 1'b1;
        out_ch.ready <= 1'b0;
        snk_wait <= HoldCycles;
      end else if (snk_wait > 0) begin
        out_ch.ready <= 1'b0;
        snk_wait <= snk_wait - 1;
      end else begin
        snk_gap = 0;
        if (snk_taken) begin
          if (snk_calm > 0) begin
            snk_calm <= snk_calm - 1;
          end else begin
            snk_gap = pick_gap();
            if ($urandom_range(0, 49) == 0) snk_calm <= $urandom_range(30, 80);
          end
        end
        if (snk_gap > 0) begin
          out_ch.ready <= 1'b0;
          snk_wait <= snk_gap - 1;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_codes.size() == 0 && due_bytes.size() == 0)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no beat for %0d cycles", $time, StuckLimit);
      $display("pcx_rle_bitplane_decoder_tb: done, errors");
      $finish;
    end
  end

  task automatic push_code(input logic [7:0] b);
    @(negedge clk_i);
    pending_codes.push_back(b);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [pcxrle_pkg::CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      pcxrle_pkg::REG_BPL:    bpl_reg = val[pcxrle_pkg::BplW-1:0];
      pcxrle_pkg::REG_WIDTH:  width_reg = val[pcxrle_pkg::WidthW-1:0];
      pcxrle_pkg::REG_HEIGHT: height_reg = val[pcxrle_pkg::HeightW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [pcxrle_pkg::CfgW-1:0] bpl,
                           input logic [pcxrle_pkg::CfgW-1:0] wid,
                           input logic [pcxrle_pkg::CfgW-1:0] hgt);
    write_reg(pcxrle_pkg::REG_BPL, bpl);
    write_reg(pcxrle_pkg::REG_WIDTH, wid);
    write_reg(pcxrle_pkg::REG_HEIGHT, hgt);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // wait until every expected beat is in, then let a trailing run header drain
  task automatic settle();
    while (pending_codes.size() != 0 || due_bytes.size() != 0 || in_ch.valid)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_random(input int n, inout int made);
    int r;
    int len;
    int target;
    target = made + n;
    while (made < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_code(8'($urandom_range(0, 191)));
        made++;
      end else if (r < 88) begin
        r = $urandom_range(0, 99);
        if (r < 10) len = 0;
        else if (r < 25) len = $urandom_range(9, 63);
        else len = $urandom_range(1, 8);
        push_code({pcxrle_pkg::RunTag, 6'(len)});
        push_code(8'($urandom_range(0, 255)));
        made += 2;
      end else begin
        push_code(8'($urandom_range(0, 255)));
        made++;
      end
    end
  endtask

  initial begin
    int made;
    int bpl;
    int wid;
    int hgt;
    int n;
    logic [7:0] directed[$];

    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.code_byte = '0;
    out_ch.ready = 1'b0;
    hold_armed = 1'b0;
    made = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: literals, runs, zero run, header as run value
    directed = '{8'h00, 8'hBF, 8'h3F, 8'h55, 8'hC3, 8'hFF, 8'hC0, 8'hAA,
                 8'hFF, 8'h0F, 8'hC2, 8'hC1};
    foreach (directed[i]) push_code(directed[i]);
    settle();

    // line length lowered below position, runs cut at line end, then past last line
    configure(17'd4, 17'd9, 17'(line_idx) + 17'd2);
    directed = '{8'hC9, 8'h81, 8'h7E, 8'hC9, 8'h81, 8'hC5, 8'h12};
    foreach (directed[i]) push_code(directed[i]);
    settle();

    // zero bytes per line, widest image
    configure(17'd0, 17'd65536, 17'd65536);
    directed = '{8'h80, 8'hC4, 8'hF0};
    foreach (directed[i]) push_code(directed[i]);
    settle();

    // zero image height
    configure(17'd65535, 17'd1, 17'd0);
    push_code(8'h33);
    settle();

    while (made < RandomItems) begin
      case ($urandom_range(0, 5))
        0: bpl = 1;
        1: bpl = 65535;
        default: bpl = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 5))
        0: wid = 1;
        1: wid = 65536;
        2: wid = (bpl * 8 > 65536) ? 65536 : bpl * 8;
        3: wid = (bpl * 8 - 3 < 1) ? 1 : ((bpl * 8 - 3 > 65536) ? 65536 : bpl * 8 - 3);
        default: wid = $urandom_range(1, 200);
      endcase
      case ($urandom_range(0, 9))
        0: hgt = 65536;
        1: hgt = int'(line_idx);
        default: hgt = int'(line_idx) + $urandom_range(1, 12);
      endcase
      configure(17'(bpl), 17'(wid), 17'(hgt));
      // long sink stall while the source keeps offering
      if (!hold_armed) hold_armed <= 1'b1;
      n = $urandom_range(20, 60);
      if (n > RandomItems - made) n = RandomItems - made;
      push_random(n, made);
      settle();
    end

    if (mismatches == 0) begin
      $display("pcx_rle_bitplane_decoder_tb: done, clean");
    end else begin
      $display("pcx_rle_bitplane_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
